// ===== rtl/lhbp_pkg.sv =====
// ---------------------------------------------------------------------------
// lhbp_pkg
// types, constants and helpers shared by the local history branch predictor
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lhbp_pkg;

  localparam int ENTRY_W          = 4;
  localparam int INDEX_CODES      = 1 << ENTRY_W;
  localparam int MISS_W           = 16;
  localparam int HIST_OUT_W       = 3;
  localparam int CTR_W            = 2;
  localparam int DEF_NUM_ENTRIES  = 16;
  localparam int DEF_HISTORY_BITS = 3;

  localparam logic [MISS_W-1:0] MISS_MAX = '1;
  localparam logic [CTR_W-1:0]  CTR_MAX  = 2'd3;
  localparam logic [CTR_W-1:0]  CTR_MIN  = 2'd0;

  typedef logic [CTR_W-1:0] ctr_t;

  typedef struct packed {
    logic [ENTRY_W-1:0] entry_index;
    logic               taken;
  } upd_item_t;

  typedef struct packed {
    logic                  predicted_taken;
    logic                  mispredicted;
    logic [MISS_W-1:0]     miss_total;
    logic [HIST_OUT_W-1:0] history_used;
  } res_item_t;

  // one saturating step toward the outcome
  function automatic ctr_t ctr_step(input ctr_t ctr, input logic taken);
    ctr_t r;
    r = ctr;
    if (taken) begin
      if (ctr != CTR_MAX) r = ctr + 2'd1;
    end else begin
      if (ctr != CTR_MIN) r = ctr - 2'd1;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/lhbp_ctr_store.sv =====
// ---------------------------------------------------------------------------
// lhbp_ctr_store
// pattern counter memory with registered read, write forwarding and a
// clearing sweep after reset
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lhbp_ctr_store
  import lhbp_pkg::*;
#(
  parameter int DEPTH  = DEF_NUM_ENTRIES << DEF_HISTORY_BITS,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire ctr_t              wr_data,
  output ctr_t                   rd_data,
  output logic                   busy
);

  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

  ctr_t              mem [DEPTH];
  ctr_t              mem_q;
  logic              fwd_hit;
  ctr_t              fwd_data;
  logic [ADDR_W-1:0] clr_addr;

  // clearing sweep, one counter a cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b1;
      clr_addr <= '0;
    end else if (busy) begin
      if (clr_addr == LAST_ADDR) busy <= 1'b0;
      clr_addr <= clr_addr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      mem[clr_addr] <= CTR_MIN;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // a write at the same edge as the read is not seen by the array read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      mem_q    <= mem[rd_addr];
      fwd_hit  <= wr_en && (wr_addr == rd_addr);
      fwd_data <= wr_data;
    end
  end

  assign rd_data = fwd_hit ? fwd_data : mem_q;

endmodule

`default_nettype wire

// ===== rtl/local_history_branch_predictor.sv =====
// ---------------------------------------------------------------------------
// local_history_branch_predictor
// two-level local history branch predictor with 2-bit pattern counters
// ---------------------------------------------------------------------------
// usage:
//   update channel (upd_valid / upd_stall / upd) carries one item per branch
//   outcome: table entry index and actual outcome. result channel
//   (res_valid / res_stall / res) returns one item per update: prediction
//   made before the update, mispredict flag, entry miss count (saturating)
//   and the history pattern that picked the counter.
//   a result passes the update stage register, then the result register;
//   one item per cycle unless res_stall or the reset sweep holds it. the
//   counter memory read is issued at the accept edge and written back as
//   the item leaves the update stage, with forwarding on the history and
//   counter paths so back-to-back items on one entry are exact.
//   reset: history and miss tables clear at once; a sweep clears the
//   NUM_ENTRIES * 2**HISTORY_BITS counters while upd_stall stays high.
//   stalls: when res_stall holds a result, the item in the update stage
//   waits, and upd_stall rises only if that stage is full.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module local_history_branch_predictor
  import lhbp_pkg::*;
#(
  parameter int NUM_ENTRIES  = DEF_NUM_ENTRIES,
  parameter int HISTORY_BITS = DEF_HISTORY_BITS
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      upd_valid,
  output logic           upd_stall,
  input  wire upd_item_t upd,
  output logic           res_valid,
  input  wire logic      res_stall,
  output res_item_t      res
);

  localparam int IDX_W     = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
  localparam int CTR_DEPTH = NUM_ENTRIES << HISTORY_BITS;
  localparam int CADDR_W   = $clog2(CTR_DEPTH);

  typedef logic [HISTORY_BITS-1:0] hist_t;
  typedef logic [IDX_W-1:0]        idx_t;

  // entry index reduction, a constant table over the input codes
  idx_t idx_lut [INDEX_CODES];
  for (genvar g = 0; g < INDEX_CODES; g++) begin : g_idx_lut
    assign idx_lut[g] = IDX_W'(g % NUM_ENTRIES);
  end

  // local history and miss counts per entry
  hist_t             hist_tab [NUM_ENTRIES];
  logic [MISS_W-1:0] miss_tab [NUM_ENTRIES];

  // update stage
  logic  s1_valid;
  idx_t  s1_idx;
  logic  s1_taken;
  hist_t s1_hist;
  logic  s1_fire;

  // accept side
  logic               upd_accept;
  idx_t               in_idx;
  hist_t              in_hist;
  logic [CADDR_W-1:0] rd_addr;
  logic [CADDR_W-1:0] wr_addr;
  logic               ctr_busy;
  ctr_t               ctr_rd;

  // update stage results
  logic              pred;
  logic              miss;
  logic [MISS_W-1:0] miss_old;
  logic [MISS_W-1:0] miss_new;
  ctr_t              ctr_new;
  hist_t             hist_new;

  assign s1_fire    = s1_valid && (!res_valid || !res_stall);
  assign upd_stall  = ctr_busy || (s1_valid && !s1_fire);
  assign upd_accept = upd_valid && !upd_stall;

  // history lookup, with the update leaving the stage this cycle forwarded
  assign in_idx  = idx_lut[upd.entry_index];
  assign in_hist = (s1_fire && (s1_idx == in_idx)) ? hist_new : hist_tab[in_idx];
  assign rd_addr = CADDR_W'({in_idx, in_hist});
  assign wr_addr = CADDR_W'({s1_idx, s1_hist});

  lhbp_ctr_store #(
    .DEPTH  (CTR_DEPTH),
    .ADDR_W (CADDR_W)
  ) u_ctr_store (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (upd_accept),
    .rd_addr (rd_addr),
    .wr_en   (s1_fire),
    .wr_addr (wr_addr),
    .wr_data (ctr_new),
    .rd_data (ctr_rd),
    .busy    (ctr_busy)
  );

  // prediction and update; miss count reads the table directly since the
  // item ahead has already written it back
  always_comb begin
    pred     = ctr_rd[1];
    miss     = pred != s1_taken;
    miss_old = miss_tab[s1_idx];
    miss_new = (miss && (miss_old != MISS_MAX)) ? miss_old + 1'b1 : miss_old;
    ctr_new  = ctr_step(ctr_rd, s1_taken);
    hist_new = HISTORY_BITS'({s1_hist, s1_taken});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (upd_accept) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (upd_accept) begin
      s1_idx   <= in_idx;
      s1_taken <= upd.taken;
      s1_hist  <= in_hist;
    end
  end

  // table write-back
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_ENTRIES; i++) begin
        hist_tab[i] <= '0;
        miss_tab[i] <= '0;
      end
    end else if (s1_fire) begin
      hist_tab[s1_idx] <= hist_new;
      miss_tab[s1_idx] <= miss_new;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (s1_fire) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      res.predicted_taken <= pred;
      res.mispredicted    <= miss;
      res.miss_total      <= miss_new;
      res.history_used    <= HIST_OUT_W'(s1_hist);
    end
  end

  // no item enters while the counter memory is being cleared
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (rst)
    ctr_busy |-> upd_stall)
    else $error("item accepted during counter clear");

  // a finished update always lands in the result register
  a_fire_shows_result: assert property (@(posedge clk) disable iff (rst)
    s1_fire |=> res_valid)
    else $error("update left stage without a result");

  // a held update stage keeps its item
  a_stage_holds: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_fire) |=> (s1_valid && $stable(s1_idx) && $stable(s1_hist)))
    else $error("held update stage changed");

  // a miss always leaves a nonzero count
  a_miss_counted: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.mispredicted) |-> (res.miss_total != '0))
    else $error("mispredict with zero miss count");

endmodule

`default_nettype wire

// ===== tb/lhbp_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lhbp_checker
// follows every accepted branch update with its own copy of the local
// history, pattern counter and miss tables, and compares each returned item
// field by field with the oldest outcome still waiting
// ---------------------------------------------------------------------------
module lhbp_checker
  import lhbp_pkg::*;
#(
  parameter int NUM_ENTRIES  = DEF_NUM_ENTRIES,
  parameter int HISTORY_BITS = DEF_HISTORY_BITS
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      upd_valid,
  input  logic      upd_stall,
  input  upd_item_t upd,
  input  logic      res_valid,
  input  logic      res_stall,
  input  res_item_t res,
  output int        errors,
  output int        outstanding,
  output int        outcomes_checked,
  output int        mispredicts_seen,
  output int        ceiling_hits
);

  localparam int PATTERNS     = 1 << HISTORY_BITS;
  localparam int REPORT_LIMIT = 10;

  logic [HISTORY_BITS-1:0] local_hist   [NUM_ENTRIES];
  ctr_t                    pattern_ctr  [NUM_ENTRIES * PATTERNS];
  logic [MISS_W-1:0]       entry_misses [NUM_ENTRIES];
  res_item_t               pending_outcomes [$];

  // one branch update: predict from the entry's history, then train
  function automatic res_item_t apply_outcome(input upd_item_t item);
    int unsigned             idx;
    int unsigned             slot;
    logic [HISTORY_BITS-1:0] hist;
    ctr_t                    ctr;
    res_item_t               r;
    idx  = item.entry_index % NUM_ENTRIES;
    hist = local_hist[idx];
    slot = idx * PATTERNS + hist;
    ctr  = pattern_ctr[slot];
    r.predicted_taken = (ctr >= 2'd2);
    r.mispredicted    = (r.predicted_taken != item.taken);
    if (r.mispredicted && entry_misses[idx] != MISS_MAX)
      entry_misses[idx] = entry_misses[idx] + 1'b1;
    if (item.taken) begin
      if (ctr != CTR_MAX) ctr = ctr + 2'd1;
    end else begin
      if (ctr != CTR_MIN) ctr = ctr - 2'd1;
    end
    pattern_ctr[slot] = ctr;
    local_hist[idx]   = HISTORY_BITS'({hist, item.taken});
    r.miss_total      = entry_misses[idx];
    r.history_used    = HIST_OUT_W'(hist);
    return r;
  endfunction

  always @(posedge clk) begin : watch
    res_item_t want;
    logic      bad;
    if (rst) begin
      foreach (local_hist[i]) local_hist[i] = '0;
      foreach (pattern_ctr[i]) pattern_ctr[i] = CTR_MIN;
      foreach (entry_misses[i]) entry_misses[i] = '0;
      pending_outcomes.delete();
      errors           = 0;
      outcomes_checked = 0;
      mispredicts_seen = 0;
      ceiling_hits     = 0;
      outstanding     <= 0;
    end else begin
      if (upd_valid && !upd_stall)
        pending_outcomes.push_back(apply_outcome(upd));
      if (res_valid && !res_stall) begin
        outcomes_checked++;
        if (pending_outcomes.size() == 0) begin
          errors++;
          if (errors <= REPORT_LIMIT)
            $display("[%0t] unexpected item: pred=%0b miss=%0b count=%0d hist=%0d",
                     $realtime, res.predicted_taken, res.mispredicted,
                     res.miss_total, res.history_used);
        end else begin
          want = pending_outcomes.pop_front();
          if (want.mispredicted) mispredicts_seen++;
          if (want.miss_total == MISS_MAX) ceiling_hits++;
          bad = (res.predicted_taken !== want.predicted_taken) ||
                (res.mispredicted    !== want.mispredicted)    ||
                (res.miss_total      !== want.miss_total)      ||
                (res.history_used    !== want.history_used);
          if (bad) begin
            errors++;
            if (errors <= REPORT_LIMIT)
              $display({"[%0t] mismatch: expected pred=%0b miss=%0b count=%0d hist=%0d,",
                        " got pred=%0b miss=%0b count=%0d hist=%0d"},
                       $realtime, want.predicted_taken, want.mispredicted,
                       want.miss_total, want.history_used, res.predicted_taken,
                       res.mispredicted, res.miss_total, res.history_used);
          end
        end
      end
      outstanding <= pending_outcomes.size();
    end
  end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// drives branch updates into the local history predictor and lets the
// checker judge every returned item: a short directed run over the counter
// limits and table extremes, then biased random traffic under three idling
// mixes and a short full-rate tail
// ---------------------------------------------------------------------------
module testbench;
  import lhbp_pkg::*;

  localparam int CLK_HALF         = 6;
  localparam int RESET_CYCLES     = 12;
  // cycle limit for the whole run, including the clearing sweep
  localparam int CYCLE_LIMIT      = 40000;
  localparam int DRAIN_CYCLES     = 16;
  localparam int RANDOM_PER_PHASE = 195;
  localparam int HOT_STRIDE       = 5;

  logic      clk       = 1'b0;
  logic      rst       = 1'b1;
  logic      upd_valid = 1'b0;
  logic      upd_stall;
  upd_item_t upd       = '0;
  logic      res_valid;
  logic      res_stall = 1'b0;
  res_item_t res;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int items_sent     = 0;
  int cycle_count    = 0;
  int taken_bias [INDEX_CODES];

  int errors;
  int outstanding;
  int outcomes_checked;
  int mispredicts_seen;
  int ceiling_hits;

  local_history_branch_predictor dut (
    .clk       (clk),
    .rst       (rst),
    .upd_valid (upd_valid),
    .upd_stall (upd_stall),
    .upd       (upd),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

  lhbp_checker u_outcome_check (
    .clk              (clk),
    .rst              (rst),
    .upd_valid        (upd_valid),
    .upd_stall        (upd_stall),
    .upd              (upd),
    .res_valid        (res_valid),
    .res_stall        (res_stall),
    .res              (res),
    .errors           (errors),
    .outstanding      (outstanding),
    .outcomes_checked (outcomes_checked),
    .mispredicts_seen (mispredicts_seen),
    .ceiling_hits     (ceiling_hits)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // result side backpressure, redrawn every cycle
  always @(posedge clk) begin
    res_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles with %0d outcomes still waiting",
               cycle_count, outstanding);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // one update item; called at a rising edge, returns at the edge that
  // accepts it with valid still high, so a following item keeps it up
  task automatic send_branch(input int entry, input logic outcome);
    upd_item_t item;
    item.entry_index = ENTRY_W'(entry);
    item.taken       = outcome;
    // sender gaps, possibly several in a row
    while ($urandom_range(0, 99) < send_idle_pct) begin
      upd_valid <= 1'b0;
      @(posedge clk);
    end
    upd       <= item;
    upd_valid <= 1'b1;
    @(posedge clk);
    // upd_stall is high through the counter clearing sweep after reset
    while (upd_stall !== 1'b0) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_run(input int entry, input logic outcome, input int count);
    repeat (count) send_branch(entry, outcome);
  endtask

  // biased traffic: mostly short bursts on a few hot entries whose outcomes
  // follow the entry's bias, so the counters train and predictions go both
  // ways; the rest is uniform noise over every entry
  task automatic run_random(input int count);
    int n;
    int entry;
    int burst;
    n = 0;
    while (n < count) begin
      if ($urandom_range(0, 99) < 60) begin
        entry = $urandom_range(0, (INDEX_CODES - 1) / HOT_STRIDE) * HOT_STRIDE;
        burst = $urandom_range(1, 8);
        for (int k = 0; k < burst && n < count; k++) begin
          send_branch(entry, $urandom_range(0, 99) < taken_bias[entry]);
          n++;
        end
      end else begin
        send_branch($urandom_range(0, INDEX_CODES - 1), 1'($urandom_range(0, 1)));
        n++;
      end
    end
  endtask

  initial begin
    // each entry leans taken, not taken or neither
    foreach (taken_bias[i]) begin
      case ($urandom_range(0, 2))
        0:       taken_bias[i] = 3;
        1:       taken_bias[i] = 50;
        default: taken_bias[i] = 97;
      endcase
    end

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // phase one: sender idles now and then, receiver stalls most cycles
    send_idle_pct   = 21;
    recv_stall_pct <= 68;

    // not-taken on a fresh entry: counter sits at its floor, no misses
    send_run(0, 1'b0, 3);
    // first taken at the all-not-taken history is a miss
    send_run(0, 1'b1, 1);
    // history fills with taken, its counter climbs and stays at the top
    send_run(INDEX_CODES - 1, 1'b1, 7);
    // a strongly taken prediction broken by a not-taken outcome
    send_run(INDEX_CODES - 1, 1'b0, 1);
    // alternating outcomes on one entry
    repeat (3) begin
      send_branch(5, 1'b1);
      send_branch(5, 1'b0);
    end
    // back-to-back updates of one entry exercise the forwarding paths
    send_branch(10, 1'b1);
    send_branch(10, 1'b0);
    send_branch(10, 1'b1);

    run_random(RANDOM_PER_PHASE);

    // phase two: the other way round
    send_idle_pct   = 68;
    recv_stall_pct <= 21;
    run_random(RANDOM_PER_PHASE);

    // phase three: full rate both ways
    send_idle_pct   = 0;
    recv_stall_pct <= 0;
    run_random(RANDOM_PER_PHASE);
    run_random(RANDOM_PER_PHASE / 4);

    // let every outstanding outcome come back, then a little longer
    upd_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d branch updates sent, %0d outcomes checked, %0d of them mispredicted",
             items_sent, outcomes_checked, mispredicts_seen);
    $display("directed counter and history cases plus three stall mixes, %0d at miss ceiling",
             ceiling_hits);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
